@@ src/sstf_disk_scheduler_assert.svh @@
// Assertion macros for the SSTF disk scheduler checker.
`ifndef SSTF_DISK_SCHEDULER_ASSERT_SVH
`define SSTF_DISK_SCHEDULER_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted.
`define SSTF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication into the following cycle.
`define SSTF_ASSERT_NXT(lbl, pre, post, msg) \
  `SSTF_ASSERT(lbl, (pre) |=> (post), msg)

`endif

@@ src/sstf_pkg.sv @@
// Shared types and constants of the SSTF disk scheduler.
package sstf_pkg;

  // Input kinds carried in s_axis_tuser
  localparam logic ACT_HEAD = 1'b0;
  localparam logic ACT_ADD  = 1'b1;

  localparam int IN_TDATA_W  = 16;
  localparam int TRK_OUT_W   = 16;
  localparam int SUM_OUT_W   = 21;
  localparam int OUT_TDATA_W = 72;

  // Saturation point of the running movement total
  localparam logic [SUM_OUT_W-1:0] SUM_LIMIT = 21'h1F_FFFF;

  // Result word, lowest field last
  typedef struct packed {
    logic [1:0]           pad;
    logic                 dropped;
    logic [SUM_OUT_W-1:0] total_movement;
    logic [TRK_OUT_W-1:0] distance;
    logic [TRK_OUT_W-1:0] to_track;
    logic [TRK_OUT_W-1:0] from_track;
  } result_t;

endpackage

@@ src/sstf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sstf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/sstf_disk_scheduler.sv @@
// SSTF disk scheduler: request store in RAM, nearest-track scan per serve.
//
//  channel  | dir | tdata                 | tuser       | tlast
//  s_axis   | in  | track                 | action      | last
//  m_axis   | out | from,to,dist,total,dr | -           | last_res
//
// Input transfers are accepted only while the block is idle.
// Each serve scans all N stored requests through the RAM read port,
// then passes through the EVAL and EMIT states before the next serve.
// The output register lets the next scan run while a result waits.
// Input is not accepted while a schedule runs; a stalled result holds.
// Reset clears control state; store entries are read only once written.
module sstf_disk_scheduler #(
  parameter int MAX_REQUESTS = 32,
  parameter int TRACK_BITS   = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [sstf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [15:0] track
  input  logic                               s_axis_tuser,   // [0] action
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [15:0] from_track, [31:16] to_track, [47:32] distance,
  // [68:48] total_movement, [69] dropped, [71:70] zero
  output logic [sstf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tlast
);
  import sstf_pkg::*;

  localparam int IDX_W = $clog2(MAX_REQUESTS);
  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam int SUM_W = ((TRACK_BITS > SUM_OUT_W) ? TRACK_BITS : SUM_OUT_W) + 1;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUESTS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [CNT_W-1:0]        pending_q, pending_d;
  logic [TRACK_BITS-1:0]   head_q, head_d;
  logic [SUM_OUT_W-1:0]    sum_q, sum_d;
  logic                    ovf_q, ovf_d;
  logic [MAX_REQUESTS-1:0] served_q, served_d;
  logic [IDX_W-1:0]        scan_idx_q, scan_idx_d;
  logic                    pipe_vld_q, pipe_vld_d;
  logic [IDX_W-1:0]        pipe_idx_q, pipe_idx_d;
  logic                    found_q, found_d;
  logic [TRACK_BITS-1:0]   best_q, best_d;
  logic [IDX_W-1:0]        pick_q, pick_d;
  logic [TRACK_BITS-1:0]   pick_trk_q, pick_trk_d;
  logic                    out_vld_q, out_vld_d;
  result_t                 out_data_q, out_data_d;
  logic                    out_last_q, out_last_d;

  logic                  in_xfer;
  logic                  store_we;
  logic [TRACK_BITS-1:0] in_trk;
  logic [TRACK_BITS-1:0] rd_data;
  logic [TRACK_BITS-1:0] seek_len;
  logic                  take;
  logic                  out_free;
  logic [SUM_W-1:0]      sum_ext;
  logic [SUM_OUT_W-1:0]  sum_sat;
  logic [CNT_W-1:0]      pending_inc;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign in_trk        = TRACK_BITS'(s_axis_tdata);
  assign store_we      = in_xfer && (s_axis_tuser == ACT_ADD) && (count_q < CNT_MAX);
  assign pending_inc   = pending_q + CNT_W'(store_we);
  assign out_free      = !out_vld_q || m_axis_tready;

  // request store
  sstf_ram #(
    .WIDTH (TRACK_BITS),
    .DEPTH (MAX_REQUESTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (in_trk),
    .re_i    (state_q == ST_SCAN),
    .raddr_i (scan_idx_q),
    .rdata_o (rd_data)
  );

  // distance of the entry just read and nearest-candidate test
  assign seek_len = (rd_data >= head_q) ? (rd_data - head_q) : (head_q - rd_data);
  assign take = pipe_vld_q && !served_q[pipe_idx_q] && (!found_q || (seek_len < best_q));

  // saturating running total
  assign sum_ext = SUM_W'(sum_q) + SUM_W'(best_q);
  assign sum_sat = (sum_ext > SUM_W'(SUM_LIMIT)) ? SUM_LIMIT : sum_ext[SUM_OUT_W-1:0];

  // control and datapath next state
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    pending_d  = pending_q;
    head_d     = head_q;
    sum_d      = sum_q;
    ovf_d      = ovf_q;
    served_d   = served_q;
    scan_idx_d = scan_idx_q;
    pipe_vld_d = 1'b0;
    pipe_idx_d = pipe_idx_q;
    found_d    = found_q;
    best_d     = best_q;
    pick_d     = pick_q;
    pick_trk_d = pick_trk_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_data_d = out_data_q;
    out_last_d = out_last_q;

    // compare stage behind the RAM read
    if (take) begin
      found_d    = 1'b1;
      best_d     = seek_len;
      pick_d     = pipe_idx_q;
      pick_trk_d = rd_data;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (s_axis_tuser == ACT_HEAD) begin
            head_d    = in_trk;
            served_d  = '0;
            count_d   = '0;
            pending_d = '0;
            sum_d     = '0;
            ovf_d     = 1'b0;
          end else begin
            if (store_we) begin
              count_d = count_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
            pending_d = pending_inc;
            if (s_axis_tlast && (pending_inc != '0)) begin
              state_d    = ST_SCAN;
              scan_idx_d = '0;
              found_d    = 1'b0;
            end
          end
        end
      end
      ST_SCAN: begin
        pipe_vld_d = 1'b1;
        pipe_idx_d = scan_idx_q;
        if (CNT_W'(scan_idx_q) == count_q - 1'b1) begin
          state_d = ST_EVAL;
        end else begin
          scan_idx_d = scan_idx_q + 1'b1;
        end
      end
      ST_EVAL: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_vld_d                 = 1'b1;
          out_data_d.pad            = '0;
          out_data_d.dropped        = ovf_q;
          out_data_d.total_movement = sum_sat;
          out_data_d.distance       = TRK_OUT_W'(best_q);
          out_data_d.to_track       = TRK_OUT_W'(pick_trk_q);
          out_data_d.from_track     = TRK_OUT_W'(head_q);
          out_last_d                = (pending_q == CNT_W'(1));
          served_d[pick_q]          = 1'b1;
          sum_d                     = sum_sat;
          head_d                    = pick_trk_q;
          pending_d                 = pending_q - 1'b1;
          if (pending_q == CNT_W'(1)) begin
            state_d = ST_IDLE;
          end else begin
            state_d    = ST_SCAN;
            scan_idx_d = '0;
            found_d    = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      pending_q  <= '0;
      head_q     <= '0;
      sum_q      <= '0;
      ovf_q      <= 1'b0;
      served_q   <= '0;
      pipe_vld_q <= 1'b0;
      found_q    <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      pending_q  <= pending_d;
      head_q     <= head_d;
      sum_q      <= sum_d;
      ovf_q      <= ovf_d;
      served_q   <= served_d;
      pipe_vld_q <= pipe_vld_d;
      found_q    <= found_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    scan_idx_q <= scan_idx_d;
    pipe_idx_q <= pipe_idx_d;
    best_q     <= best_d;
    pick_q     <= pick_d;
    pick_trk_q <= pick_trk_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

@@ src/sstf_checker.sv @@
// Port-level checker for the SSTF disk scheduler, bound to the top level.
`include "sstf_disk_scheduler_assert.svh"

module sstf_checker #(
  parameter int TRACK_BITS = 16
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             s_axis_tuser,   // [0] action
  input logic                             s_axis_tlast,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  // [15:0] from, [31:16] to, [47:32] distance, [68:48] total, [69] dropped
  input logic [sstf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tlast
);
  import sstf_pkg::*;

  result_t               res;
  logic                  chain_q;
  logic [TRK_OUT_W-1:0]  prev_to_q;
  logic [TRK_OUT_W-1:0]  abs_gap;
  logic                  out_xfer;

  assign res      = result_t'(m_axis_tdata);
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign abs_gap  = (res.to_track >= res.from_track) ? (res.to_track - res.from_track)
                                                     : (res.from_track - res.to_track);

  // track the head across the serves of one schedule
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= 1'b0;
    end else if (out_xfer) begin
      chain_q <= !m_axis_tlast;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_xfer) begin
      prev_to_q <= res.to_track;
    end
  end

  // a stalled result holds
  `SSTF_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed under stall")

  // distance matches the head movement
  `SSTF_ASSERT(a_dist,
    !m_axis_tvalid || (TRACK_BITS > TRK_OUT_W) || (res.distance == abs_gap), "distance mismatch")

  // each serve starts where the previous one ended
  `SSTF_ASSERT(a_chain, !(m_axis_tvalid && chain_q) || (res.from_track == prev_to_q), "head chain broken")

  // input stalls only after a request transfer that starts a schedule
  `SSTF_ASSERT(a_busy, !$fell(s_axis_tready) ||
    $past(s_axis_tvalid && (s_axis_tuser == ACT_ADD) && s_axis_tlast), "unexpected busy")

endmodule

bind sstf_disk_scheduler sstf_checker #(.TRACK_BITS(TRACK_BITS)) u_sstf_checker (.*);
